// ===== rtl/batr_pkg.sv =====
package batr_pkg;

  localparam int unsigned CAP_W     = 16;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned TEXT_W    = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned DIV_STEPS = 7;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 16'd128;
  localparam logic [TEXT_W-1:0] TEXT_MAX_LEN = 8'd255;
  localparam logic [LEN_W-1:0]  WORD_BYTES   = 9'd4;
  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;

  localparam logic [2:0] KIND_QUERY = 3'd0;
  localparam logic [2:0] KIND_TEXT  = 3'd1;
  localparam logic [2:0] KIND_WORD  = 3'd2;
  localparam logic [2:0] KIND_FREE  = 3'd3;
  localparam logic [2:0] KIND_GROW  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_BADIDX   = 3'd5;
  localparam logic [2:0] ST_FREED    = 3'd6;
  localparam logic [2:0] ST_GROW_REJ = 3'd7;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_idx;
    logic get_end;
    logic scan;
    logic apply;
    logic mul;
    logic div;
    logic finish;
  } batr_cmd_t;

  typedef struct packed {
    logic free_go;
    logic scan_done;
    logic div_last;
  } batr_sts_t;

endpackage

// ===== rtl/batr_ram.sv =====
module batr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/batr_dp.sv =====
module batr_dp import batr_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  batr_cmd_t         cmd,
  output batr_sts_t         sts,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_data,
  input  logic [2:0]        in_kind,
  input  logic [TEXT_W-1:0] in_text_length,
  input  logic [5:0]        in_slot_index,
  input  logic [CAP_W-1:0]  in_new_capacity,
  output logic              out_strobe,
  output logic [2:0]        out_status,
  output logic [5:0]        out_assigned_slot,
  output logic [CAP_W-1:0]  out_assigned_offset,
  output logic              out_tail_reclaimed,
  output logic [CAP_W-1:0]  out_cursor_now,
  output logic [CAP_W-1:0]  out_capacity_now,
  output logic [PCT_W-1:0]  out_free_percent
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned USED_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CMP_W  = (USED_W > 6) ? USED_W : 6;
  localparam int unsigned ENT_W  = CAP_W + LEN_W;
  localparam int unsigned NUM_W  = CAP_W + PCT_W;

  logic [2:0]              kind_r;
  logic [TEXT_W-1:0]       tlen_r;
  logic [5:0]              idx_r;
  logic [CAP_W-1:0]        ncap_r;
  logic [CAP_W-1:0]        cap_r;
  logic [CAP_W-1:0]        cursor_r;
  logic [USED_W-1:0]       used_r;
  logic [USED_W-1:0]       act_cnt_r;
  logic [SLOT_COUNT-1:0]   active_r;
  logic [2:0]              status_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [CAP_W-1:0]        offset_r;
  logic                    recl_r;
  logic [CAP_W:0]          end_r;
  logic                    after_r;
  logic [CAP_W:0]          top_r;
  logic [USED_W-1:0]       scan_i_r;
  logic                    proc_v_r;
  logic [SLOT_W-1:0]       proc_i_r;
  logic [CAP_W-1:0]        rem_r;
  logic [PCT_W-1:0]        lo_r;
  logic [PCT_W-1:0]        quo_r;
  logic [2:0]              div_cnt_r;
  logic                    strobe_r;
  logic [2:0]              ostatus_r;
  logic [5:0]              oslot_r;
  logic [CAP_W-1:0]        ooffset_r;
  logic                    orecl_r;
  logic [CAP_W-1:0]        ocursor_r;
  logic [CAP_W-1:0]        ocap_r;
  logic [PCT_W-1:0]        opct_r;

  logic [SLOT_W-1:0]       idx_slot;
  logic [SLOT_W-1:0]       used_slot;
  logic [TEXT_W-1:0]       tlen_sat;
  logic [LEN_W-1:0]        need;
  logic [CAP_W:0]          alloc_sum;
  logic [2:0]              alloc_status;
  logic [2:0]              free_status;
  logic [2:0]              grow_status;
  logic [2:0]              dec_status;
  logic                    is_alloc;
  logic                    alloc_ok;
  logic                    ram_we;
  logic [SLOT_W-1:0]       raddr;
  logic [ENT_W-1:0]        rdata;
  logic [CAP_W-1:0]        rd_start;
  logic [LEN_W-1:0]        rd_len;
  logic [CAP_W:0]          rd_end;
  logic                    scan_issue;
  logic [NUM_W-1:0]        num;
  logic [CAP_W:0]          rem_sh;
  logic                    fits;
  logic [CAP_W:0]          rem_sub;
  logic [PCT_W-1:0]        pct;

  assign idx_slot  = SLOT_W'(idx_r);
  assign used_slot = used_r[SLOT_W-1:0];
  assign tlen_sat  = (tlen_r > TEXT_MAX_LEN) ? TEXT_MAX_LEN : tlen_r;
  assign is_alloc  = (kind_r == KIND_TEXT) || (kind_r == KIND_WORD);

  always_comb begin
    if (kind_r == KIND_TEXT) begin
      need = (tlen_sat == '0) ? '0 : LEN_W'(tlen_sat) + LEN_W'(1);
    end else begin
      need = WORD_BYTES;
    end
  end

  assign alloc_sum = {1'b0, cursor_r} + (CAP_W + 1)'(need);

  always_comb begin
    if (used_r >= USED_W'(SLOT_COUNT)) begin
      alloc_status = ST_FULL;
    end else if (need == '0) begin
      alloc_status = ST_EMPTY;
    end else if (alloc_sum > {1'b0, cap_r}) begin
      alloc_status = ST_NOSPACE;
    end else begin
      alloc_status = ST_OK;
    end
  end

  always_comb begin
    if (act_cnt_r == '0) begin
      free_status = ST_NONE;
    end else if (CMP_W'(idx_r) >= CMP_W'(used_r)) begin
      free_status = ST_BADIDX;
    end else if (!active_r[idx_slot]) begin
      free_status = ST_FREED;
    end else begin
      free_status = ST_OK;
    end
  end

  assign grow_status = ((ncap_r == '0) || (ncap_r <= cap_r)) ? ST_GROW_REJ : ST_OK;

  always_comb begin
    case (kind_r)
      KIND_TEXT: dec_status = alloc_status;
      KIND_WORD: dec_status = alloc_status;
      KIND_FREE: dec_status = free_status;
      KIND_GROW: dec_status = grow_status;
      default:   dec_status = ST_OK;
    endcase
  end

  assign alloc_ok      = is_alloc && (alloc_status == ST_OK);
  assign ram_we        = cmd.exec && alloc_ok;
  assign sts.free_go   = (kind_r == KIND_FREE) && (free_status == ST_OK);

  assign raddr      = cmd.rd_idx ? idx_slot : scan_i_r[SLOT_W-1:0];
  assign rd_start   = rdata[ENT_W-1:LEN_W];
  assign rd_len     = rdata[LEN_W-1:0];
  assign rd_end     = {1'b0, rd_start} + (CAP_W + 1)'(rd_len);
  assign scan_issue = scan_i_r < used_r;

  assign sts.scan_done = !scan_issue && !proc_v_r;
  assign sts.div_last  = div_cnt_r == 3'(DIV_STEPS - 1);

  assign num = (NUM_W'(cursor_r) << 6) + (NUM_W'(cursor_r) << 5) + (NUM_W'(cursor_r) << 2);

  assign rem_sh  = {rem_r, lo_r[PCT_W-1]};
  assign fits    = rem_sh >= {1'b0, cap_r};
  assign rem_sub = rem_sh - {1'b0, cap_r};

  assign pct = ((cap_r == '0) || (quo_r >= PCT_FULL)) ? '0 : PCT_FULL - quo_r;

  batr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(used_slot),
    .wdata({cursor_r, need}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      cursor_r  <= '0;
      used_r    <= '0;
      act_cnt_r <= '0;
      active_r  <= '0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
      if (cfg_we) begin
        cap_r     <= cfg_data;
        cursor_r  <= '0;
        used_r    <= '0;
        act_cnt_r <= '0;
        active_r  <= '0;
      end else begin
        if (cmd.exec && alloc_ok) begin
          active_r[used_slot] <= 1'b1;
          used_r              <= used_r + USED_W'(1);
          act_cnt_r           <= act_cnt_r + USED_W'(1);
          cursor_r            <= alloc_sum[CAP_W-1:0];
        end
        if (cmd.exec && (kind_r == KIND_GROW) && (grow_status == ST_OK)) begin
          cap_r <= ncap_r;
        end
        if (cmd.apply) begin
          active_r[idx_slot] <= 1'b0;
          act_cnt_r          <= act_cnt_r - USED_W'(1);
          if (!after_r) begin
            cursor_r <= top_r[CAP_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      tlen_r <= in_text_length;
      idx_r  <= in_slot_index;
      ncap_r <= in_new_capacity;
    end
    if (cmd.exec) begin
      status_r <= dec_status;
      slot_r   <= alloc_ok ? used_slot : '0;
      offset_r <= alloc_ok ? cursor_r : '0;
      recl_r   <= 1'b0;
    end
    if (cmd.get_end) begin
      end_r    <= rd_end;
      after_r  <= 1'b0;
      top_r    <= '0;
      scan_i_r <= '0;
      proc_v_r <= 1'b0;
    end
    if (cmd.scan) begin
      if (scan_issue) begin
        scan_i_r <= scan_i_r + USED_W'(1);
      end
      proc_v_r <= scan_issue;
      proc_i_r <= raddr;
      if (proc_v_r && (proc_i_r != idx_slot) && active_r[proc_i_r]) begin
        if ({1'b0, rd_start} >= end_r) begin
          after_r <= 1'b1;
        end
        if (rd_end > top_r) begin
          top_r <= rd_end;
        end
      end
    end
    if (cmd.apply) begin
      recl_r <= !after_r;
    end
    if (cmd.mul) begin
      rem_r     <= num[NUM_W-1:PCT_W];
      lo_r      <= num[PCT_W-1:0];
      quo_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div) begin
      rem_r     <= fits ? rem_sub[CAP_W-1:0] : rem_sh[CAP_W-1:0];
      lo_r      <= {lo_r[PCT_W-2:0], 1'b0};
      quo_r     <= {quo_r[PCT_W-2:0], fits};
      div_cnt_r <= div_cnt_r + 3'd1;
    end
    if (cmd.finish) begin
      ostatus_r <= status_r;
      oslot_r   <= 6'(slot_r);
      ooffset_r <= offset_r;
      orecl_r   <= recl_r;
      ocursor_r <= cursor_r;
      ocap_r    <= cap_r;
      opct_r    <= pct;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = ostatus_r;
  assign out_assigned_slot   = oslot_r;
  assign out_assigned_offset = ooffset_r;
  assign out_tail_reclaimed  = orecl_r;
  assign out_cursor_now      = ocursor_r;
  assign out_capacity_now    = ocap_r;
  assign out_free_percent    = opct_r;

endmodule

// ===== rtl/batr_ctrl.sv =====
module batr_ctrl import batr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  batr_sts_t sts,
  output batr_cmd_t cmd,
  output logic      idle
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_RDIDX  = 4'd2;
  localparam logic [3:0] S_END    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_APPLY  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.free_go ? S_RDIDX : S_MUL;
      end
      S_RDIDX: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_END;
      end
      S_END: begin
        cmd.get_end = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = state_r == S_IDLE;

endmodule

// ===== rtl/bump_allocator_tail_reclaim_unit.sv =====
// Channel   Handshake                     Payload
// input     start & !busy                 in_kind, in_text_length, in_slot_index,
//                                         in_new_capacity
// result    out_strobe, one cycle         out_status, out_assigned_slot,
//                                         out_assigned_offset, out_tail_reclaimed,
//                                         out_cursor_now, out_capacity_now,
//                                         out_free_percent
// config    cfg_valid & cfg_ready         cfg_data
//
// Query, allocate, grow and a rejected free go through decide and the divider.
// A free that passes its checks also scans the slot table first: one read of the
// slot table per used slot, then a 7-step shift-subtract divider for the free percentage.
// Synchronous active-low reset; capacity comes up at 128 with no slots used.
// The result strobe cannot be held off; busy and cfg_ready hold a new
// transaction off while one is in progress.
module bump_allocator_tail_reclaim_unit import batr_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_kind,
  input  logic [TEXT_W-1:0] in_text_length,
  input  logic [5:0]        in_slot_index,
  input  logic [CAP_W-1:0]  in_new_capacity,
  output logic              out_strobe,
  output logic [2:0]        out_status,
  output logic [5:0]        out_assigned_slot,
  output logic [CAP_W-1:0]  out_assigned_offset,
  output logic              out_tail_reclaimed,
  output logic [CAP_W-1:0]  out_cursor_now,
  output logic [CAP_W-1:0]  out_capacity_now,
  output logic [PCT_W-1:0]  out_free_percent,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  batr_cmd_t cmd;
  batr_sts_t sts;
  logic      idle;

  assign busy      = !idle;
  assign cfg_ready = idle;

  batr_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .idle (idle)
  );

  batr_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_text_length     (in_text_length),
    .in_slot_index      (in_slot_index),
    .in_new_capacity    (in_new_capacity),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_assigned_slot  (out_assigned_slot),
    .out_assigned_offset(out_assigned_offset),
    .out_tail_reclaimed (out_tail_reclaimed),
    .out_cursor_now     (out_cursor_now),
    .out_capacity_now   (out_capacity_now),
    .out_free_percent   (out_free_percent)
  );

endmodule
